[rtl/two_register_float_calculator_machine_defines.svh]
`ifndef TWO_REGISTER_FLOAT_CALCULATOR_MACHINE_DEFINES_SVH
`define TWO_REGISTER_FLOAT_CALCULATOR_MACHINE_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define TRFC_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TRFC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/trfc_pkg.sv]
`timescale 1ns / 1ps
package trfc_pkg;

  typedef enum logic [3:0] {
    OP_INPUT   = 4'd0,
    OP_DISPLAY = 4'd1,
    OP_LOAD    = 4'd2,
    OP_STORE   = 4'd3,
    OP_MUL     = 4'd4,
    OP_DIV     = 4'd5,
    OP_SQRT    = 4'd6,
    OP_ADD     = 4'd7,
    OP_SUB     = 4'd8,
    OP_FINISH  = 4'd9
  } op_e;

  typedef enum logic [2:0] {
    FOP_MUL,
    FOP_DIV,
    FOP_SQRT,
    FOP_ADD,
    FOP_SUB
  } fop_e;

  typedef struct packed {
    logic start;
    fop_e op;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } fpu_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MEMRD,
    ST_FPU,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    FS_IDLE,
    FS_PRENORM,
    FS_MUL,
    FS_DIV,
    FS_SQRT,
    FS_ALIGN,
    FS_SUM,
    FS_NORM,
    FS_ROUND,
    FS_DONE
  } fstate_e;

  localparam logic [63:0] CanonNan = 64'h7FF8_0000_0000_0000;
  localparam logic [62:0] InfMag   = 63'h7FF0_0000_0000_0000;
  localparam int unsigned NormW    = 110;

endpackage

[rtl/trfc_store.sv]
`timescale 1ns / 1ps
module trfc_store #(
  parameter int unsigned WORDS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [$clog2(WORDS)-1:0]   wr_addr_i,
  input  logic [63:0]                wr_data_i,
  input  logic                       rd_en_i,
  input  logic [$clog2(WORDS)-1:0]   rd_addr_i,
  output logic [63:0]                rd_data_o,
  output logic                       clr_busy_o
);

  localparam int unsigned AddrW = $clog2(WORDS);

  logic [63:0]      mem [WORDS];
  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;
  logic             clr_busy_q, clr_busy_d;
  logic [63:0]      rd_data_q;

  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      if (clr_cnt_q == AddrW'(WORDS - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_cnt_d = clr_cnt_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_cnt_q  <= clr_cnt_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  // zeroing sweep owns the write port until it finishes
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clr_busy_o = clr_busy_q;

endmodule

[rtl/trfc_fpu.sv]
`timescale 1ns / 1ps
`include "two_register_float_calculator_machine_defines.svh"
module trfc_fpu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  trfc_pkg::fpu_req_t req_i,
  input  logic [63:0]        a_i,
  input  logic [63:0]        b_i,
  output trfc_pkg::fpu_rsp_t rsp_o
);
  import trfc_pkg::*;

  fstate_e fstate_q, fstate_d;
  fop_e    fop_q, fop_d;

  logic               sa_q, sa_d, sb_q, sb_d;
  logic signed [13:0] ea_q, ea_d, eb_q, eb_d;
  logic [52:0]        ma_q, ma_d, mb_q, mb_d;
  logic [5:0]         cnt_q, cnt_d;
  logic [106:0]       prod_q, prod_d;
  logic [53:0]        rem_q, rem_d;
  logic [56:0]        quo_q, quo_d;
  logic [59:0]        sr_q, sr_d;
  logic [55:0]        sq_q, sq_d;
  logic [55:0]        smsh_q, smsh_d;
  logic [NormW-1:0]   bsh_q, bsh_d;
  logic [13:0]        dist_q, dist_d;
  logic               effsub_q, effsub_d;
  logic [NormW-1:0]   nm_q, nm_d;
  logic signed [13:0] nbe_q, nbe_d;
  logic               nstk_q, nstk_d;
  logic               nsgn_q, nsgn_d;
  logic [63:0]        res_q, res_d;

  // operand classes at start
  logic a_nan, a_inf, a_zero, b_nan, b_inf, b_zero, sbe, sx;
  logic spec_hit;
  logic [63:0] spec_val;

  // step datapath
  logic [53:0]        mul_hi;
  logic               div_ge;
  logic [53:0]        div_rem;
  logic [59:0]        sq_r2, sq_t;
  logic               sq_ge;
  logic               a_big;
  logic signed [13:0] sq_big;
  logic [NormW-1:0]   al_sh;
  logic [NormW-1:0]   sum_v;
  logic [52:0]        rn_mant;
  logic               rn_inc;
  logic [53:0]        rn_sum;
  logic signed [13:0] rn_exp;

  assign a_nan  = (&a_i[62:52]) && (|a_i[51:0]);
  assign a_inf  = (&a_i[62:52]) && !(|a_i[51:0]);
  assign a_zero = (a_i[62:0] == '0);
  assign b_nan  = (&b_i[62:52]) && (|b_i[51:0]);
  assign b_inf  = (&b_i[62:52]) && !(|b_i[51:0]);
  assign b_zero = (b_i[62:0] == '0);
  assign sbe    = b_i[63] ^ (req_i.op == FOP_SUB);
  assign sx     = a_i[63] ^ b_i[63];

  always_comb begin
    spec_hit = 1'b1;
    spec_val = CanonNan;
    unique case (req_i.op)
      FOP_MUL: begin
        if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) spec_val = CanonNan;
        else if (a_inf || b_inf) spec_val = {sx, InfMag};
        else if (a_zero || b_zero) spec_val = {sx, 63'd0};
        else spec_hit = 1'b0;
      end
      FOP_DIV: begin
        if (a_nan || b_nan) spec_val = CanonNan;
        else if (b_zero) spec_val = a_zero ? CanonNan : {sx, InfMag};
        else if (a_inf) spec_val = b_inf ? CanonNan : {sx, InfMag};
        else if (b_inf || a_zero) spec_val = {sx, 63'd0};
        else spec_hit = 1'b0;
      end
      FOP_SQRT: begin
        if (a_nan) spec_val = CanonNan;
        else if (a_zero) spec_val = a_i;
        else if (a_i[63]) spec_val = CanonNan;
        else if (a_inf) spec_val = a_i;
        else spec_hit = 1'b0;
      end
      FOP_ADD, FOP_SUB: begin
        if (a_nan || b_nan) spec_val = CanonNan;
        else if (a_inf && b_inf && (a_i[63] != sbe)) spec_val = CanonNan;
        else if (a_inf) spec_val = a_i;
        else if (b_inf) spec_val = {sbe, InfMag};
        else if (a_zero && b_zero) spec_val = {a_i[63] & sbe, 63'd0};
        else if (a_zero) spec_val = {sbe, b_i[62:0]};
        else if (b_zero) spec_val = a_i;
        else spec_hit = 1'b0;
      end
      default: spec_val = CanonNan;
    endcase
  end

  assign mul_hi  = prod_q[106:53] + (prod_q[0] ? {1'b0, ma_q} : 54'd0);
  assign div_ge  = (rem_q >= {1'b0, mb_q});
  assign div_rem = div_ge ? (rem_q - {1'b0, mb_q}) : rem_q;
  assign sq_r2   = {sr_q[57:0], smsh_q[55:54]};
  assign sq_t    = {2'b00, sq_q, 2'b01};
  assign sq_ge   = (sq_r2 >= sq_t);
  assign a_big   = (ea_q > eb_q) || ((ea_q == eb_q) && (ma_q >= mb_q));
  assign sq_big  = ea_q - 14'sd1075 - (ea_q[0] ? 14'sd0 : 14'sd1);
  assign al_sh   = bsh_q >> dist_q[6:0];
  assign sum_v   = effsub_q ? (nm_q - bsh_q) : (nm_q + bsh_q);

  assign rn_mant = nm_q[NormW-1 -: 53];
  assign rn_inc  = nm_q[NormW-54] & ((|nm_q[NormW-55:0]) | nstk_q | rn_mant[0]);
  assign rn_sum  = {1'b0, rn_mant} + {53'd0, rn_inc};
  assign rn_exp  = rn_sum[53] ? (nbe_q + 14'sd1) : (rn_sum[52] ? nbe_q : 14'sd0);

  always_comb begin
    fstate_d = fstate_q;
    fop_d    = fop_q;
    sa_d = sa_q;  sb_d = sb_q;  ea_d = ea_q;  eb_d = eb_q;
    ma_d = ma_q;  mb_d = mb_q;  cnt_d = cnt_q;
    prod_d = prod_q;  rem_d = rem_q;  quo_d = quo_q;
    sr_d = sr_q;  sq_d = sq_q;  smsh_d = smsh_q;
    bsh_d = bsh_q;  dist_d = dist_q;  effsub_d = effsub_q;
    nm_d = nm_q;  nbe_d = nbe_q;  nstk_d = nstk_q;  nsgn_d = nsgn_q;
    res_d = res_q;
    unique case (fstate_q)
      FS_IDLE: begin
        if (req_i.start) begin
          fop_d = req_i.op;
          sa_d  = a_i[63];
          sb_d  = sbe;
          ea_d  = (a_i[62:52] == '0) ? 14'sd1 : $signed({3'b000, a_i[62:52]});
          eb_d  = (b_i[62:52] == '0) ? 14'sd1 : $signed({3'b000, b_i[62:52]});
          ma_d  = {a_i[62:52] != '0, a_i[51:0]};
          mb_d  = {b_i[62:52] != '0, b_i[51:0]};
          if (spec_hit) begin
            res_d    = spec_val;
            fstate_d = FS_DONE;
          end else begin
            fstate_d = FS_PRENORM;
          end
        end
      end
      FS_PRENORM: begin
        // bring subnormal mantissas up to the hidden-bit position
        if (!ma_q[52]) begin
          ma_d = {ma_q[51:0], 1'b0};
          ea_d = ea_q - 14'sd1;
        end
        if (!mb_q[52] && fop_q != FOP_SQRT) begin
          mb_d = {mb_q[51:0], 1'b0};
          eb_d = eb_q - 14'sd1;
        end
        if (ma_q[52] && (mb_q[52] || fop_q == FOP_SQRT)) begin
          nsgn_d = sa_q ^ sb_q;
          nstk_d = 1'b0;
          unique case (fop_q)
            FOP_MUL: begin
              prod_d   = {54'd0, mb_q};
              cnt_d    = 6'd53;
              nbe_d    = ea_q + eb_q - 14'sd1022;
              fstate_d = FS_MUL;
            end
            FOP_DIV: begin
              rem_d    = {1'b0, ma_q};
              quo_d    = '0;
              cnt_d    = 6'd57;
              nbe_d    = ea_q - eb_q + 14'sd1023;
              fstate_d = FS_DIV;
            end
            FOP_SQRT: begin
              smsh_d   = ea_q[0] ? {3'b000, ma_q} : {2'b00, ma_q, 1'b0};
              sr_d     = '0;
              sq_d     = '0;
              cnt_d    = 6'd56;
              nbe_d    = (sq_big >>> 1) + 14'sd1049;
              nsgn_d   = 1'b0;
              fstate_d = FS_SQRT;
            end
            default: begin
              nsgn_d   = a_big ? sa_q : sb_q;
              nbe_d    = (a_big ? ea_q : eb_q) + 14'sd1;
              nm_d     = {1'b0, (a_big ? ma_q : mb_q), 56'd0};
              bsh_d    = {1'b0, (a_big ? mb_q : ma_q), 56'd0};
              dist_d   = 14'(a_big ? (ea_q - eb_q) : (eb_q - ea_q));
              effsub_d = sa_q ^ sb_q;
              fstate_d = FS_ALIGN;
            end
          endcase
        end
      end
      FS_MUL: begin
        // shift-add, one multiplier bit per cycle
        if (cnt_q != '0) begin
          prod_d = {1'b0, mul_hi, prod_q[52:1]};
          cnt_d  = cnt_q - 6'd1;
        end else begin
          nm_d     = {prod_q[105:0], 4'd0};
          fstate_d = FS_NORM;
        end
      end
      FS_DIV: begin
        // restoring division, one quotient bit per cycle
        if (cnt_q != '0) begin
          quo_d = {quo_q[55:0], div_ge};
          rem_d = {div_rem[52:0], 1'b0};
          cnt_d = cnt_q - 6'd1;
        end else begin
          nm_d     = {quo_q, 53'd0};
          nstk_d   = (rem_q != '0);
          fstate_d = FS_NORM;
        end
      end
      FS_SQRT: begin
        // digit recurrence, one root bit per cycle
        if (cnt_q != '0) begin
          sr_d   = sq_ge ? (sq_r2 - sq_t) : sq_r2;
          sq_d   = {sq_q[54:0], sq_ge};
          smsh_d = {smsh_q[53:0], 2'b00};
          cnt_d  = cnt_q - 6'd1;
        end else begin
          nm_d     = {sq_q[54:0], 55'd0};
          nstk_d   = (sr_q != '0);
          fstate_d = FS_NORM;
        end
      end
      FS_ALIGN: begin
        // shifted-out bits jam into the lsb
        if (dist_q >= 14'(NormW)) begin
          bsh_d = {{(NormW-1){1'b0}}, |bsh_q};
        end else begin
          bsh_d = al_sh | {{(NormW-1){1'b0}}, ((al_sh << dist_q[6:0]) != bsh_q)};
        end
        fstate_d = FS_SUM;
      end
      FS_SUM: begin
        nm_d = sum_v;
        if (sum_v == '0) nsgn_d = 1'b0;
        fstate_d = FS_NORM;
      end
      FS_NORM: begin
        if (nm_q == '0) begin
          res_d    = {nsgn_q, 63'd0};
          fstate_d = FS_DONE;
        end else if (nbe_q < 14'sd1) begin
          nm_d   = nm_q >> 1;
          nstk_d = nstk_q | nm_q[0];
          nbe_d  = nbe_q + 14'sd1;
        end else if (!nm_q[NormW-1] && nbe_q > 14'sd1) begin
          nm_d  = nm_q << 1;
          nbe_d = nbe_q - 14'sd1;
        end else begin
          fstate_d = FS_ROUND;
        end
      end
      FS_ROUND: begin
        if (rn_exp >= 14'sd2047) res_d = {nsgn_q, InfMag};
        else res_d = {nsgn_q, rn_exp[10:0], rn_sum[51:0]};
        fstate_d = FS_DONE;
      end
      FS_DONE: begin
        fstate_d = FS_IDLE;
      end
      default: fstate_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fstate_q <= FS_IDLE;
    end else begin
      fstate_q <= fstate_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fop_q <= fop_d;
    sa_q <= sa_d;  sb_q <= sb_d;  ea_q <= ea_d;  eb_q <= eb_d;
    ma_q <= ma_d;  mb_q <= mb_d;  cnt_q <= cnt_d;
    prod_q <= prod_d;  rem_q <= rem_d;  quo_q <= quo_d;
    sr_q <= sr_d;  sq_q <= sq_d;  smsh_q <= smsh_d;
    bsh_q <= bsh_d;  dist_q <= dist_d;  effsub_q <= effsub_d;
    nm_q <= nm_d;  nbe_q <= nbe_d;  nstk_q <= nstk_d;  nsgn_q <= nsgn_d;
    res_q <= res_d;
  end

  assign rsp_o.done   = (fstate_q == FS_DONE);
  assign rsp_o.result = res_q;

  `TRFC_ASSERT(a_start_idle, req_i.start, fstate_q == FS_IDLE, "fpu start while busy")
  `TRFC_ASSERT(a_nan_canon, rsp_o.done && (&rsp_o.result[62:52]) && (|rsp_o.result[51:0]), rsp_o.result == CanonNan, "non-canonical NaN")
  `TRFC_ASSERT(a_prenorm_live, fstate_q == FS_PRENORM, (ma_q != '0) && (fop_q == FOP_SQRT || mb_q != '0), "zero mantissa in prenormalize")

endmodule

[rtl/two_register_float_calculator_machine.sv]
`timescale 1ns / 1ps
`include "two_register_float_calculator_machine_defines.svh"
// Channel  Dir  Handshake                  Beat payload
// in       in   in_valid_i / in_ready_o    op_i, address_i, value_i
// out      out  out_valid_o / out_ready_i  shown_value_o, shown_valid_o, halted_o
//
// Input, display, store, finish: idle, then done; memory load: idle, read, then done.
// Arithmetic runs on the shared iterative FP unit: prenormalize, then multiply, divide,
//   square root or align and sum, then normalize, round and hand-back.
// Reset starts a zeroing sweep of the store; in_ready_o stays low meanwhile.
// A finished beat waits in the output register; the next beat is taken while it waits.
module two_register_float_calculator_machine #(
  parameter int unsigned STORE_WORDS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  op_i,
  input  logic [5:0]  address_i,
  input  logic [63:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] shown_value_o,
  output logic        shown_valid_o,
  output logic        halted_o
);
  import trfc_pkg::*;

  localparam int unsigned AddrW = $clog2(STORE_WORDS);
  localparam int unsigned CalcW = ((AddrW > 6) ? AddrW : 6) + 1;

  state_e state_q, state_d;

  // machine registers
  logic [63:0] r1_q, r1_d, r2_q, r2_d;
  logic        r1_occ_q, r1_occ_d, r2_occ_q, r2_occ_d;
  logic        stopped_q, stopped_d;
  logic        is_sqrt_q, is_sqrt_d;

  // result of the current item, waiting for the output register
  logic [63:0] pend_shown_q, pend_shown_d;
  logic        pend_valid_q, pend_valid_d;

  logic        out_valid_q, out_valid_d;
  logic [63:0] out_shown_q, out_shown_d;
  logic        out_sv_q, out_sv_d;
  logic        out_halt_q, out_halt_d;

  logic             in_beat;
  logic [CalcW-1:0] addr_acc;
  logic [AddrW-1:0] addr_idx;

  logic             st_wr_en, st_rd_en, clr_busy;
  logic [63:0]      st_rd_data;

  fpu_req_t fpu_req;
  fpu_rsp_t fpu_rsp;

  // address wrap: at most seven subtracts since the store has at least 8 words
  always_comb begin
    addr_acc = CalcW'(address_i);
    for (int k = 0; k < 8; k++) begin
      if (addr_acc >= CalcW'(STORE_WORDS)) addr_acc = addr_acc - CalcW'(STORE_WORDS);
    end
  end
  assign addr_idx = addr_acc[AddrW-1:0];

  assign in_ready_o = (state_q == ST_IDLE) && !clr_busy;
  assign in_beat    = in_valid_i && in_ready_o;

  always_comb begin
    state_d      = state_q;
    r1_d         = r1_q;
    r2_d         = r2_q;
    r1_occ_d     = r1_occ_q;
    r2_occ_d     = r2_occ_q;
    stopped_d    = stopped_q;
    is_sqrt_d    = is_sqrt_q;
    pend_shown_d = pend_shown_q;
    pend_valid_d = pend_valid_q;
    out_valid_d  = out_valid_q;
    out_shown_d  = out_shown_q;
    out_sv_d     = out_sv_q;
    out_halt_d   = out_halt_q;
    st_wr_en     = 1'b0;
    st_rd_en     = 1'b0;
    fpu_req.start = 1'b0;
    fpu_req.op    = FOP_MUL;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          pend_shown_d = '0;
          pend_valid_d = 1'b0;
          state_d      = ST_DONE;
          if (!stopped_q) begin
            unique case (op_i)
              OP_INPUT: begin
                if (r1_occ_q) begin
                  r2_d     = value_i;
                  r2_occ_d = 1'b1;
                end else begin
                  r1_d     = value_i;
                  r1_occ_d = 1'b1;
                  r2_d     = '0;
                  r2_occ_d = 1'b0;
                end
              end
              OP_DISPLAY: begin
                pend_shown_d = r1_q;
                pend_valid_d = 1'b1;
                r1_d     = '0;
                r1_occ_d = 1'b0;
                r2_d     = '0;
                r2_occ_d = 1'b0;
              end
              OP_LOAD: begin
                st_rd_en = 1'b1;
                state_d  = ST_MEMRD;
              end
              OP_STORE: begin
                st_wr_en = 1'b1;
                r1_occ_d = 1'b0;
              end
              OP_MUL, OP_DIV, OP_SQRT, OP_ADD, OP_SUB: begin
                fpu_req.start = 1'b1;
                unique case (op_i)
                  OP_MUL:  fpu_req.op = FOP_MUL;
                  OP_DIV:  fpu_req.op = FOP_DIV;
                  OP_SQRT: fpu_req.op = FOP_SQRT;
                  OP_ADD:  fpu_req.op = FOP_ADD;
                  default: fpu_req.op = FOP_SUB;
                endcase
                is_sqrt_d = (op_i == OP_SQRT);
                state_d   = ST_FPU;
              end
              OP_FINISH: stopped_d = 1'b1;
              default: ;  // unused opcodes do nothing
            endcase
          end
        end
      end
      ST_MEMRD: begin
        // memory word goes into the first free register; register 2 untouched when it fills register 1
        if (r1_occ_q) begin
          r2_d     = st_rd_data;
          r2_occ_d = 1'b1;
        end else begin
          r1_d     = st_rd_data;
          r1_occ_d = 1'b1;
        end
        state_d = ST_DONE;
      end
      ST_FPU: begin
        if (fpu_rsp.done) begin
          r1_d = fpu_rsp.result;
          if (!is_sqrt_q) begin
            r2_d     = '0;
            r2_occ_d = 1'b0;
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_shown_d = pend_shown_q;
          out_sv_d    = pend_valid_q;
          out_halt_d  = stopped_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      r1_q        <= '0;
      r2_q        <= '0;
      r1_occ_q    <= 1'b0;
      r2_occ_q    <= 1'b0;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      r1_q        <= r1_d;
      r2_q        <= r2_d;
      r1_occ_q    <= r1_occ_d;
      r2_occ_q    <= r2_occ_d;
      stopped_q   <= stopped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_sqrt_q    <= is_sqrt_d;
    pend_shown_q <= pend_shown_d;
    pend_valid_q <= pend_valid_d;
    out_shown_q  <= out_shown_d;
    out_sv_q     <= out_sv_d;
    out_halt_q   <= out_halt_d;
  end

  trfc_store #(
    .WORDS(STORE_WORDS)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (st_wr_en),
    .wr_addr_i  (addr_idx),
    .wr_data_i  (r1_q),
    .rd_en_i    (st_rd_en),
    .rd_addr_i  (addr_idx),
    .rd_data_o  (st_rd_data),
    .clr_busy_o (clr_busy)
  );

  trfc_fpu u_fpu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fpu_req),
    .a_i    (r1_q),
    .b_i    (r2_q),
    .rsp_o  (fpu_rsp)
  );

  assign out_valid_o   = out_valid_q;
  assign shown_value_o = out_shown_q;
  assign shown_valid_o = out_sv_q;
  assign halted_o      = out_halt_q;

  `TRFC_ASSERT_NXT(a_halt_sticky, stopped_q, stopped_q, "halt flag dropped")
  `TRFC_ASSERT(a_fpu_done_wait, fpu_rsp.done, state_q == ST_FPU, "fpu result with no op waiting")
  `TRFC_ASSERT_NXT(a_done_emits, state_q == ST_DONE && !out_valid_q, out_valid_q, "result not moved to output")

endmodule
